// ===== sv/char_lcd_nibble_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// char lcd nibble sequencer assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CLNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/clns_pkg.sv =====
// ----------------------------------------------------------------------------
// clns_pkg
// types, codes and strobe table shared by the lcd nibble sequencer
// ----------------------------------------------------------------------------
package clns_pkg;

    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int COL_W   = 6;
    localparam int STEP_W  = 4;
    localparam int CFG_IDX_W = 2;

    // request kinds
    typedef enum logic [1:0] {
        OP_INSTR  = 2'd0,
        OP_DATA   = 2'd1,
        OP_CURSOR = 2'd2,
        OP_INIT   = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SETTLE_TICKS = 2'd2;

    localparam logic [TICK_W-1:0] RST_INIT_GAP_TICKS    = 16'd1500;
    localparam logic [TICK_W-1:0] RST_INIT_SETTLE_TICKS = 16'd10000;

    localparam logic [BYTE_W-1:0] CURSOR_BASE    = 8'h80;
    localparam logic [BYTE_W-1:0] CURSOR_ROW_OFS = 8'h40;

    localparam logic [NIB_W-1:0] WAKE_NIBBLE  = 4'h3;
    localparam logic [NIB_W-1:0] FOUR_BIT_NIB = 4'h2;

    // step layout of the init sequence
    localparam logic [STEP_W-1:0] INIT_SWITCH_STEP = 4'd3;
    localparam logic [STEP_W-1:0] INIT_INSTR_STEP  = 4'd4;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP   = 4'd11;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP   = 4'd1;

    localparam logic [BYTE_W-1:0] INIT_INSTR [4] = '{8'h0C, 8'h01, 8'h02, 8'h0C};

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              reg_select;
        logic [TICK_W-1:0] wait_before;
        logic [TICK_W-1:0] wait_after;
        logic              last;
    } t_strobe;

    // one strobe of a request, picked by its step number
    function automatic t_strobe f_strobe(
        input t_op               op,
        input logic [BYTE_W-1:0] byte_val,
        input logic [STEP_W-1:0] step,
        input logic [TICK_W-1:0] gap,
        input logic [TICK_W-1:0] settle
    );
        t_strobe           s;
        logic [STEP_W-1:0] ofs;
        logic [BYTE_W-1:0] instr;
        ofs   = step - INIT_INSTR_STEP;
        instr = INIT_INSTR[ofs[2:1]];
        s     = '0;
        case (op)
            OP_INIT: begin
                if (step < INIT_SWITCH_STEP) begin
                    s.nibble      = WAKE_NIBBLE;
                    s.wait_before = gap;
                end else if (step == INIT_SWITCH_STEP) begin
                    s.nibble      = FOUR_BIT_NIB;
                    s.wait_before = gap;
                end else begin
                    s.nibble      = ofs[0] ? instr[3:0] : instr[7:4];
                    s.wait_before = (step == INIT_INSTR_STEP) ? gap : '0;
                    s.wait_after  = (step == INIT_LAST_STEP) ? settle : '0;
                end
                s.last = (step == INIT_LAST_STEP);
            end
            default: begin
                s.nibble     = step[0] ? byte_val[3:0] : byte_val[7:4];
                s.reg_select = (op == OP_DATA);
                s.last       = (step == BYTE_LAST_STEP);
            end
        endcase
        return s;
    endfunction

endpackage

// ===== sv/clns_ctrl.sv =====
// ----------------------------------------------------------------------------
// clns_ctrl
// request/strobe sequencing state machine
// ----------------------------------------------------------------------------
module clns_ctrl import clns_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEND;
                end
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/clns_datapath.sv =====
// ----------------------------------------------------------------------------
// clns_datapath
// request hold, step counter, strobe output register and config registers
// ----------------------------------------------------------------------------
module clns_datapath import clns_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_wdata,
    input  t_op                  i_op,
    input  logic [BYTE_W-1:0]    i_byte_value,
    input  logic [COL_W-1:0]     i_column,
    input  logic                 i_row,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_strobe              o_strobe
);

    logic [TICK_W-1:0] r_init_gap, r_init_settle;
    t_op               r_op;
    logic [BYTE_W-1:0] r_byte;
    logic [STEP_W-1:0] r_step;
    t_strobe           r_strobe;

    logic [BYTE_W-1:0] n_byte;
    logic [STEP_W-1:0] n_step;

    // cursor requests become a set-address instruction
    always_comb begin
        if (i_op == OP_CURSOR) begin
            n_byte = CURSOR_BASE + {{(BYTE_W-COL_W){1'b0}}, i_column}
                     + (i_row ? CURSOR_ROW_OFS : '0);
        end else begin
            n_byte = i_byte_value;
        end
        n_step = r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_gap    <= RST_INIT_GAP_TICKS;
            r_init_settle <= RST_INIT_SETTLE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INIT_GAP_TICKS:    r_init_gap    <= i_cfg_wdata;
                CFG_INIT_SETTLE_TICKS: r_init_settle <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_byte   <= n_byte;
            r_step   <= '0;
            r_strobe <= f_strobe(i_op, n_byte, '0, r_init_gap, r_init_settle);
        end else if (i_cmd.advance) begin
            r_step   <= n_step;
            r_strobe <= f_strobe(r_op, r_byte, n_step, r_init_gap, r_init_settle);
        end
    end

    assign o_stat.last = r_strobe.last;
    assign o_strobe    = r_strobe;

endmodule

// ===== sv/char_lcd_nibble_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top
// turns lcd requests into 4-bit enable strobe descriptors
// ----------------------------------------------------------------------------
// usage
//   slave stream takes one request per transaction: tuser carries the kind
//   (instruction, data, cursor position, initialise), tdata the byte, column
//   and row. master stream gives one transaction per enable strobe, with the
//   nibble, the waits before and after in ticks, rs on tuser and tlast on the
//   final strobe of the request
//   a request is taken only while no strobe is pending; the first strobe is
//   offered in the cycle after acceptance, then one strobe per cycle while the
//   receiver takes them
//   per request: 2 strobes for byte and cursor kinds, 12 for initialise; the
//   step counter walks the strobe table one entry per cycle while the
//   receiver takes the strobes
//   a stalled receiver holds the current strobe in the output register and
//   keeps the slave side closed
//   reset clears the state machine and loads the gap and settle registers
//   with their defaults; a write to the pulse width index (0) has no register
//   behind it and does not change any strobe field
//   config writes are registered, no read-back
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top import clns_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_wdata,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,  // byte_value[7:0], column[13:8], row[14]
    input  logic [1:0]           i_s_axis_tuser,  // op[1:0]
    // strobe stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [39:0]          o_m_axis_tdata,  // nibble[3:0], wait_before[19:4],
                                                  // wait_after[35:20]
    output logic [0:0]           o_m_axis_tuser,  // reg_select[0]
    output logic                 o_m_axis_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_strobe  w_strobe;

    // sequencing control
    clns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // request hold and strobe generation
    clns_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (t_op'(i_s_axis_tuser)),
        .i_byte_value (i_s_axis_tdata[7:0]),
        .i_column     (i_s_axis_tdata[13:8]),
        .i_row        (i_s_axis_tdata[14]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_strobe     (w_strobe)
    );

    // pack the strobe, padding tdata to whole bytes
    assign o_m_axis_tdata = {4'b0000, w_strobe.wait_after, w_strobe.wait_before,
                             w_strobe.nibble};
    assign o_m_axis_tuser = w_strobe.reg_select;
    assign o_m_axis_tlast = w_strobe.last;

endmodule

// ===== sv/clns_checker.sv =====
// ----------------------------------------------------------------------------
// clns_checker
// port-level checks on request and strobe sequencing
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_sequencer_top_macros.svh"

module clns_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic                 o_m_axis_tlast
);

    // a request is never taken while a strobe is pending
    `CLNS_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready,
        "request accepted while strobe pending")

    // an accepted request produces a strobe next cycle
    `CLNS_ASSERT_NEXT(a_req_to_strobe, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, o_m_axis_tvalid,
        "no strobe after request")

    // a strobe without tlast is followed by another
    `CLNS_ASSERT_NEXT(a_continue, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid,
        "strobe run cut short")

    // the final strobe reopens the request side
    `CLNS_ASSERT_NEXT(a_release, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast,
        !o_m_axis_tvalid && o_s_axis_tready,
        "request side not released after final strobe")

endmodule

bind char_lcd_nibble_sequencer_top clns_checker u_clns_checker (.*);

// ===== tb/tb_char_lcd_nibble_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer_top
// self-checking bench for the lcd nibble sequencer: lcd requests go in on the
// slave stream, and every enable strobe that comes out is checked field by
// field against a strobe list worked out inside the bench from the request and
// the bench's own copy of the timing registers
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_top import clns_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // bench timing
    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int STALL_MAX       = 18;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_ITEMS     = 19;
    localparam int FINAL_ITEMS     = 20;

    // lcd command set as the bench understands it
    localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] LCD_ROW2_OFS    = 8'h40;
    localparam logic [3:0] LCD_WAKE_NIB    = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB    = 4'h2;
    localparam logic [7:0] LCD_SETUP_SEQ [4] = '{8'h0C, 8'h01, 8'h02, 8'h0C};

    // register index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TICK_W-1:0]    i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata;  // byte_value[7:0], column[13:8], row[14]
    logic [1:0]           i_s_axis_tuser;  // op[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [39:0]          o_m_axis_tdata;  // nibble[3:0], wait_before[19:4],
                                           // wait_after[35:20]
    logic [0:0]           o_m_axis_tuser;  // reg_select[0]
    logic                 o_m_axis_tlast;

    // bench copy of the timing registers
    logic [TICK_W-1:0] lcd_pulse_ticks;
    logic [TICK_W-1:0] lcd_gap_ticks;
    logic [TICK_W-1:0] lcd_settle_ticks;

    // strobes still owed by the block, oldest first
    t_strobe pending_strobes[$];

    int error_count;
    int quiet_cycles;
    int rx_hold_req;
    bit tx_gaps_on;
    bit rx_stalls_on;

    char_lcd_nibble_sequencer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // strobe prediction
    // ------------------------------------------------------------------------

    function automatic void queue_strobe(input logic [3:0] nib, input logic rs,
                                         input logic [TICK_W-1:0] before_ticks,
                                         input logic [TICK_W-1:0] after_ticks,
                                         input logic final_one);
        t_strobe s;
        s.nibble      = nib;
        s.reg_select  = rs;
        s.wait_before = before_ticks;
        s.wait_after  = after_ticks;
        s.last        = final_one;
        pending_strobes.push_back(s);
    endfunction

    // a whole byte goes out high nibble first; the leading wait sits on the
    // high nibble and the trailing wait on the low one
    function automatic void queue_byte_strobes(input logic [7:0] value, input logic rs,
                                               input logic [TICK_W-1:0] before_ticks,
                                               input logic [TICK_W-1:0] after_ticks,
                                               input logic final_one);
        queue_strobe(value[7:4], rs, before_ticks, '0, 1'b0);
        queue_strobe(value[3:0], rs, '0, after_ticks, final_one);
    endfunction

    function automatic void predict_lcd_strobes(input t_op op, input logic [7:0] byte_val,
                                                input logic [5:0] col, input logic row);
        logic [7:0] ddram_cmd;
        case (op)
            OP_INSTR: queue_byte_strobes(byte_val, 1'b0, '0, '0, 1'b1);
            OP_DATA:  queue_byte_strobes(byte_val, 1'b1, '0, '0, 1'b1);
            OP_CURSOR: begin
                // set ddram address: second line starts at 0x40
                ddram_cmd = LCD_SET_DDRAM + {2'b00, col} + (row ? LCD_ROW2_OFS : 8'h00);
                queue_byte_strobes(ddram_cmd, 1'b0, '0, '0, 1'b1);
            end
            default: begin
                // wake-up nibbles, switch to 4-bit mode, then the setup bytes;
                // the settle wait hangs off the very last strobe
                repeat (3) queue_strobe(LCD_WAKE_NIB, 1'b0, lcd_gap_ticks, '0, 1'b0);
                queue_strobe(LCD_4BIT_NIB, 1'b0, lcd_gap_ticks, '0, 1'b0);
                for (int i = 0; i < 4; i++) begin
                    queue_byte_strobes(LCD_SETUP_SEQ[i], 1'b0,
                                       (i == 0) ? lcd_gap_ticks : '0,
                                       (i == 3) ? lcd_settle_ticks : '0,
                                       i == 3);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // strobe checking and watchdog, all sampled at the rising edge
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned seen);
        if (want != seen) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: strobe %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, seen);
        end
    endfunction

    always @(posedge i_clk) begin : strobe_checker
        t_strobe seen;
        t_strobe want;
        if (i_rst_n) begin
            // anything accepted on either side counts as progress
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.nibble      = o_m_axis_tdata[3:0];
                seen.wait_before = o_m_axis_tdata[19:4];
                seen.wait_after  = o_m_axis_tdata[35:20];
                seen.reg_select  = o_m_axis_tuser[0];
                seen.last        = o_m_axis_tlast;
                if (pending_strobes.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: strobe with nothing expected, nibble 0x%0h",
                                 $time, seen.nibble);
                end else begin
                    want = pending_strobes.pop_front();
                    compare_field("nibble", want.nibble, seen.nibble);
                    compare_field("reg_select", want.reg_select, seen.reg_select);
                    compare_field("wait_before", want.wait_before, seen.wait_before);
                    compare_field("wait_after", want.wait_after, seen.wait_after);
                    compare_field("last", want.last, seen.last);
                end
            end

            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d strobes outstanding",
                         $time, quiet_cycles, pending_strobes.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // strobe receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------

    initial begin : strobe_receiver
        int stall_left;
        stall_left      = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, STALL_MAX);
            end
            if (stall_left != 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared request and register tasks; all entered just after a falling edge
    // ------------------------------------------------------------------------

    task automatic send_request(input t_op op, input logic [7:0] byte_val,
                                input logic [5:0] col, input logic row);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(negedge i_clk);
        end
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {1'b0, row, col, byte_val};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_lcd_strobes(op, byte_val, col, row);
        // valid stays high, the next call either reloads it or drops it
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        t_op op;
        // initialise is long, keep it to roughly one request in ten
        if ($urandom_range(0, 9) == 0)
            op = OP_INIT;
        else
            op = t_op'($urandom_range(0, 2));
        send_request(op, 8'($urandom), 6'($urandom), 1'($urandom));
    endtask

    // block is idle once the last owed strobe has gone out
    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (pending_strobes.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            CFG_PULSE_TICKS:       lcd_pulse_ticks  = value;
            CFG_INIT_GAP_TICKS:    lcd_gap_ticks    = value;
            CFG_INIT_SETTLE_TICKS: lcd_settle_ticks = value;
            default: ;  // no register there
        endcase
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return TICK_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values of gap and settle must show up on a first initialise
    task automatic test_reset_defaults();
        send_request(OP_INIT, 8'hFF, 6'h3F, 1'b1);
        send_request(OP_INSTR, 8'h28, 6'h00, 1'b0);
        wait_drained();
    endtask

    // byte kinds at their extremes, cursor fields set to junk to prove they are ignored
    task automatic test_byte_requests();
        send_request(OP_INSTR, 8'h00, 6'h3F, 1'b1);
        send_request(OP_INSTR, 8'hFF, 6'h2A, 1'b0);
        send_request(OP_INSTR, 8'h5A, 6'h15, 1'b1);
        send_request(OP_DATA, 8'h00, 6'h3F, 1'b1);
        send_request(OP_DATA, 8'hFF, 6'h00, 1'b0);
        send_request(OP_DATA, 8'hA5, 6'h2A, 1'b1);
        wait_drained();
    endtask

    // both rows, first and last column; byte field is junk here
    task automatic test_cursor_requests();
        send_request(OP_CURSOR, 8'hFF, 6'd0, 1'b0);
        send_request(OP_CURSOR, 8'hA5, 6'd63, 1'b0);
        send_request(OP_CURSOR, 8'h5A, 6'd0, 1'b1);
        send_request(OP_CURSOR, 8'h00, 6'd63, 1'b1);
        send_request(OP_CURSOR, 8'hC3, 6'd21, 1'b1);
        wait_drained();
    endtask

    // timing registers at both ends, and a write to the empty index
    task automatic test_register_extremes();
        write_reg(CFG_PULSE_TICKS, '0);
        write_reg(CFG_INIT_GAP_TICKS, '0);
        write_reg(CFG_INIT_SETTLE_TICKS, '1);
        send_request(OP_INIT, 8'h00, 6'h00, 1'b0);
        wait_drained();
        write_reg(CFG_PULSE_TICKS, '1);
        write_reg(CFG_INIT_GAP_TICKS, '1);
        write_reg(CFG_INIT_SETTLE_TICKS, '0);
        send_request(OP_INIT, 8'h3C, 6'h2A, 1'b1);
        send_request(OP_DATA, 8'h41, 6'h00, 1'b0);
        wait_drained();
        // nothing may change after this one
        write_reg(CFG_NO_REG, 16'h1234);
        send_request(OP_INIT, 8'hFF, 6'h3F, 1'b0);
        wait_drained();
    endtask

    // receiver holds off for a long while so the block stalls on its held strobe and closes its input
    task automatic test_output_backpressure();
        rx_hold_req = HOLD_OFF_CYCLES;
        send_request(OP_INIT, 8'h00, 6'h00, 1'b0);
        repeat (7) send_random_request();
        wait_drained();
    endtask

    // random traffic in phases, registers rewritten between phases, idling varied
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            repeat ($urandom_range(1, 3))
                write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_ticks());
            tx_gaps_on   = (phase != 2);
            rx_stalls_on = (phase != 1);
            repeat (PHASE_ITEMS) send_random_request();
        end
        wait_drained();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_reg(CFG_INIT_GAP_TICKS, pick_ticks());
        write_reg(CFG_INIT_SETTLE_TICKS, pick_ticks());
        repeat (FINAL_ITEMS) send_random_request();
        wait_drained();
    endtask

    initial begin : test_sequence
        error_count      = 0;
        quiet_cycles     = 0;
        rx_hold_req      = 0;
        tx_gaps_on       = 1'b1;
        rx_stalls_on     = 1'b1;
        lcd_pulse_ticks  = 16'd150;
        lcd_gap_ticks    = 16'd1500;
        lcd_settle_ticks = 16'd10000;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_wdata      = '0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = '0;
        i_s_axis_tuser   = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_byte_requests();
        test_cursor_requests();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_full_rate();

        // catch any strobe beyond the last one owed
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
